### hw/rtl/tsp_pkg.sv
// shared types, segment bounds and line coefficient tables for the tanh / sech2 unit
package tsp_pkg;

    // field widths
    localparam int X_W     = 32;
    localparam int TANH_W  = 12;
    localparam int SECH_W  = 24;
    localparam int SLOPE_W = 22;
    localparam int ICPT_W  = 45;
    localparam int PROD_W  = X_W + SLOPE_W;
    localparam int ACC_W   = PROD_W + 2;

    // result bit positions inside the line sum
    localparam int TANH_SHIFT = 33;
    localparam int SECH_SHIFT = 22;

    // segment counts
    localparam int TANH_SEGS = 12;
    localparam int SECH_SEGS = 14;
    localparam int SEG_W     = 4;

    typedef logic signed [X_W-1:0] x_t;
    typedef logic [SEG_W-1:0]      seg_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [ICPT_W-1:0]  icpt;
    } tsp_coef_t;

    typedef struct packed {
        tsp_coef_t tanh_coef;
        tsp_coef_t sech_coef;
    } tsp_coef_pair_t;

    // lower bounds of segments 1 and up, a bound belongs to the segment above it
    localparam x_t TANH_BOUND [TANH_SEGS-1] = '{
        -32'sd6291456, -32'sd4194304, -32'sd3145728, -32'sd2097152, -32'sd1048576,
        32'sd0, 32'sd1048576, 32'sd2097152, 32'sd3145728, 32'sd4194304, 32'sd6291456
    };

    localparam x_t SECH_BOUND [SECH_SEGS-1] = '{
        -32'sd6291456, -32'sd4194304, -32'sd3145728, -32'sd2097152, -32'sd1048576,
        -32'sd419430, 32'sd0, 32'sd419430, 32'sd1048576, 32'sd2097152,
        32'sd3145728, 32'sd4194304, 32'sd6291456
    };

    // tanh slope and intercept per segment
    function automatic tsp_coef_t tanh_coef_lookup(input seg_t seg);
        tsp_coef_t c;
        c.slope = '0;
        c.icpt  = '0;
        case (seg)
            4'd0:
            begin
                c.slope = 22'sd1536;
                c.icpt  = -45'sd8796093022208;
            end
            4'd1:
            begin
                c.slope = 22'sd61440;
                c.icpt  = -45'sd7971899106027;
            end
            4'd2:
            begin
                c.slope = 22'sd243199;
                c.icpt  = -45'sd6597069766656;
            end
            4'd3:
            begin
                c.slope = 22'sd596479;
                c.icpt  = -45'sd4398046511104;
            end
            4'd4:
            begin
                c.slope = 22'sd1243647;
                c.icpt  = -45'sd1649267441664;
            end
            4'd5, 4'd6:
            begin
                c.slope = 22'sd1998335;
                c.icpt  = 45'sd0;
            end
            4'd7:
            begin
                c.slope = 22'sd1243647;
                c.icpt  = 45'sd1649267441664;
            end
            4'd8:
            begin
                c.slope = 22'sd596479;
                c.icpt  = 45'sd4398046511104;
            end
            4'd9:
            begin
                c.slope = 22'sd243199;
                c.icpt  = 45'sd6597069766656;
            end
            4'd10:
            begin
                c.slope = 22'sd61440;
                c.icpt  = 45'sd7971899106027;
            end
            4'd11:
            begin
                c.slope = 22'sd1536;
                c.icpt  = 45'sd8796093022208;
            end
            default:
            begin
                c.slope = '0;
                c.icpt  = '0;
            end
        endcase
        return c;
    endfunction

    // sech2 slope and intercept per segment
    function automatic tsp_coef_t sech_coef_lookup(input seg_t seg);
        tsp_coef_t c;
        c.slope = '0;
        c.icpt  = '0;
        case (seg)
            4'd0:
            begin
                c.slope = 22'sd8115;
                c.icpt  = 45'sd157450065097;
            end
            4'd1:
            begin
                c.slope = 22'sd118313;
                c.icpt  = 45'sd1513807609121;
            end
            4'd2:
            begin
                c.slope = 22'sd449105;
                c.icpt  = 45'sd4332955422739;
            end
            4'd3:
            begin
                c.slope = 22'sd988194;
                c.icpt  = 45'sd7708016315360;
            end
            4'd4:
            begin
                c.slope = 22'sd1552234;
                c.icpt  = 45'sd10152450566232;
            end
            4'd5:
            begin
                c.slope = 22'sd1255513;
                c.icpt  = 45'sd9603574361646;
            end
            4'd6:
            begin
                c.slope = 22'sd450119;
                c.icpt  = 45'sd8867341375687;
            end
            4'd7:
            begin
                c.slope = -22'sd450119;
                c.icpt  = 45'sd8867341375687;
            end
            4'd8:
            begin
                c.slope = -22'sd1255513;
                c.icpt  = 45'sd9603574361646;
            end
            4'd9:
            begin
                c.slope = -22'sd1552234;
                c.icpt  = 45'sd10152450566232;
            end
            4'd10:
            begin
                c.slope = -22'sd988194;
                c.icpt  = 45'sd7708016315360;
            end
            4'd11:
            begin
                c.slope = -22'sd449105;
                c.icpt  = 45'sd4332955422739;
            end
            4'd12:
            begin
                c.slope = -22'sd118313;
                c.icpt  = 45'sd1513807609121;
            end
            4'd13:
            begin
                c.slope = -22'sd8115;
                c.icpt  = 45'sd157450065097;
            end
            default:
            begin
                c.slope = '0;
                c.icpt  = '0;
            end
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/tanh_sech2_piecewise_linear_unit.sv
// top level: piecewise linear tanh and sech2 of a Q11.21 argument
//
// Input channel: x_value (signed Q11.21) with in_valid / in_ready.
// Output channel: tanh_value (signed Q2.10) and sech2_value (signed Q3.21)
// with out_valid / out_ready; every input transaction yields exactly one
// output transaction, in order.
// A result passes the input register, then the result register, before it
// is offered. Throughput: one transaction per cycle while out_ready stays
// high; the path between the two registers is a segment compare, a 22x32
// multiply and one 56-bit add per function.
// Reset clears both valid flags; the data registers are not reset, and the
// block is ready right after reset.
// When the receiver stalls, the result register holds its transaction and
// the input register keeps taking one more; in_ready falls only when both
// registers are full and out_ready is low.
module tanh_sech2_piecewise_linear_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [tsp_pkg::X_W-1:0]        x_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tsp_pkg::TANH_W-1:0]     tanh_value,
    output logic signed [tsp_pkg::SECH_W-1:0]     sech2_value
);

    logic                                in_valid_reg;
    tsp_pkg::x_t                         x_reg;
    logic                                out_valid_reg;
    logic signed [tsp_pkg::TANH_W-1:0]   tanh_reg;
    logic signed [tsp_pkg::SECH_W-1:0]   sech2_reg;
    logic signed [tsp_pkg::TANH_W-1:0]   tanh_next;
    logic signed [tsp_pkg::SECH_W-1:0]   sech2_next;

    logic                                out_load;
    logic                                in_fire;
    tsp_pkg::tsp_coef_pair_t             coef;
    logic signed [tsp_pkg::ACC_W-1:0]    tanh_acc;
    logic signed [tsp_pkg::ACC_W-1:0]    sech_acc;

    // flow control between the two register stages
    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || out_load;
    assign in_fire  = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= x_value;
        end
    end

    // segment selection and coefficients
    tsp_coef_lut u_coef_lut (
        .x    (x_reg),
        .coef (coef)
    );

    // line evaluation for each function
    tsp_line_eval u_tanh_eval (
        .x    (x_reg),
        .coef (coef.tanh_coef),
        .acc  (tanh_acc)
    );

    tsp_line_eval u_sech_eval (
        .x    (x_reg),
        .coef (coef.sech_coef),
        .acc  (sech_acc)
    );

    // arithmetic shift and truncation to the result widths
    assign tanh_next  = tanh_acc[tsp_pkg::TANH_SHIFT +: tsp_pkg::TANH_W];
    assign sech2_next = sech_acc[tsp_pkg::SECH_SHIFT +: tsp_pkg::SECH_W];

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            tanh_reg  <= tanh_next;
            sech2_reg <= sech2_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tanh_value  = tanh_reg;
    assign sech2_value = sech2_reg;

`ifndef SYNTHESIS
    // an accepted transaction lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_valid_reg)
    else $error("accepted transaction not captured");

    // a waiting argument holds while the result register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_load) |=> (in_valid_reg && $stable(x_reg)))
    else $error("stalled argument lost or changed");

    // an empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
    else $error("input stalled with empty result register");

    // a pending argument moves into the result register when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_load) |=> out_valid_reg)
    else $error("pending argument not moved to result register");
`endif

endmodule

### hw/rtl/tsp_coef_lut.sv
// segment search and coefficient lookup for both approximations
module tsp_coef_lut (
    input  tsp_pkg::x_t             x,
    output tsp_pkg::tsp_coef_pair_t coef
);

    tsp_pkg::seg_t tanh_seg;
    tsp_pkg::seg_t sech_seg;

    // tanh segment: first bound above x, outer segment when none
    always_comb
    begin
        tanh_seg = tsp_pkg::seg_t'(tsp_pkg::TANH_SEGS - 1);
        for (int i = tsp_pkg::TANH_SEGS - 2; i >= 0; i--)
        begin
            if (x < tsp_pkg::TANH_BOUND[i])
            begin
                tanh_seg = tsp_pkg::seg_t'(i);
            end
        end
    end

    // sech2 segment, same rule on its own bounds
    always_comb
    begin
        sech_seg = tsp_pkg::seg_t'(tsp_pkg::SECH_SEGS - 1);
        for (int i = tsp_pkg::SECH_SEGS - 2; i >= 0; i--)
        begin
            if (x < tsp_pkg::SECH_BOUND[i])
            begin
                sech_seg = tsp_pkg::seg_t'(i);
            end
        end
    end

    // coefficient tables
    always_comb
    begin
        coef.tanh_coef = tsp_pkg::tanh_coef_lookup(tanh_seg);
        coef.sech_coef = tsp_pkg::sech_coef_lookup(sech_seg);
    end

endmodule

### hw/rtl/tsp_line_eval.sv
// one line evaluation a*x*2 + b at full precision
module tsp_line_eval (
    input  tsp_pkg::x_t                          x,
    input  tsp_pkg::tsp_coef_t                   coef,
    output logic signed [tsp_pkg::ACC_W-1:0]     acc
);

    logic signed [tsp_pkg::PROD_W-1:0] prod;

    // signed product of slope and argument
    assign prod = tsp_pkg::PROD_W'(coef.slope) * tsp_pkg::PROD_W'(x);

    // doubled product plus intercept, exact in the accumulator width
    assign acc = (tsp_pkg::ACC_W'(prod) <<< 1) + tsp_pkg::ACC_W'(coef.icpt);

endmodule

### tb/tanh_sech2_piecewise_linear_unit_tb.sv
// testbench for the piecewise linear tanh / sech2 unit
`timescale 1ns / 100ps

module tanh_sech2_piecewise_linear_unit_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_IDLE    = 17;
    localparam int SETTLE_CYC  = 8;

    typedef struct packed {
        logic signed [tsp_pkg::TANH_W-1:0] tanh_q;
        logic signed [tsp_pkg::SECH_W-1:0] sech2_q;
    } curve_pair_t;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              in_valid    = 1'b0;
    logic                              in_ready;
    logic signed [tsp_pkg::X_W-1:0]    x_value     = '0;
    logic                              out_valid;
    logic                              out_ready   = 1'b0;
    logic signed [tsp_pkg::TANH_W-1:0] tanh_value;
    logic signed [tsp_pkg::SECH_W-1:0] sech2_value;

    // idling switches for the two sides
    bit source_gaps = 1'b0;
    bit sink_stalls = 1'b0;

    curve_pair_t expected_pairs [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    // segment lower bounds and line coefficients
    longint tanh_knee [tsp_pkg::TANH_SEGS-1] = '{
        -64'sd6291456, -64'sd4194304, -64'sd3145728, -64'sd2097152, -64'sd1048576,
        64'sd0, 64'sd1048576, 64'sd2097152, 64'sd3145728, 64'sd4194304, 64'sd6291456
    };
    longint tanh_gain [tsp_pkg::TANH_SEGS] = '{
        64'sd1536, 64'sd61440, 64'sd243199, 64'sd596479, 64'sd1243647, 64'sd1998335,
        64'sd1998335, 64'sd1243647, 64'sd596479, 64'sd243199, 64'sd61440, 64'sd1536
    };
    longint tanh_offset [tsp_pkg::TANH_SEGS] = '{
        -64'sd8796093022208, -64'sd7971899106027, -64'sd6597069766656,
        -64'sd4398046511104, -64'sd1649267441664, 64'sd0, 64'sd0, 64'sd1649267441664,
        64'sd4398046511104, 64'sd6597069766656, 64'sd7971899106027, 64'sd8796093022208
    };
    longint sech_knee [tsp_pkg::SECH_SEGS-1] = '{
        -64'sd6291456, -64'sd4194304, -64'sd3145728, -64'sd2097152, -64'sd1048576,
        -64'sd419430, 64'sd0, 64'sd419430, 64'sd1048576, 64'sd2097152,
        64'sd3145728, 64'sd4194304, 64'sd6291456
    };
    longint sech_gain [tsp_pkg::SECH_SEGS] = '{
        64'sd8115, 64'sd118313, 64'sd449105, 64'sd988194, 64'sd1552234, 64'sd1255513,
        64'sd450119, -64'sd450119, -64'sd1255513, -64'sd1552234, -64'sd988194,
        -64'sd449105, -64'sd118313, -64'sd8115
    };
    longint sech_offset [tsp_pkg::SECH_SEGS] = '{
        64'sd157450065097, 64'sd1513807609121, 64'sd4332955422739, 64'sd7708016315360,
        64'sd10152450566232, 64'sd9603574361646, 64'sd8867341375687,
        64'sd8867341375687, 64'sd9603574361646, 64'sd10152450566232,
        64'sd7708016315360, 64'sd4332955422739, 64'sd1513807609121, 64'sd157450065097
    };

    // arguments at and around the segment boundaries, plus the range extremes and two bit patterns
    tsp_pkg::x_t boundary_args [24] = '{
        32'sh80000000, 32'sh7fffffff, -32'sd6291456, -32'sd6291457, -32'sd4194304,
        -32'sd3145728, -32'sd2097152, -32'sd1048576, -32'sd419430, -32'sd419431,
        -32'sd1, 32'sd0, 32'sd1, 32'sd419430, 32'sd419429, 32'sd1048576,
        32'sd2097152, 32'sd3145728, 32'sd4194304, 32'sd6291455, 32'sd6291456,
        32'sd6291457, 32'sh55555555, 32'shaaaaaaaa
    };

    tanh_sech2_piecewise_linear_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_value     (x_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tanh_value  (tanh_value),
        .sech2_value (sech2_value)
    );

    always #5 clk = ~clk;

    // expected tanh and sech2 of one argument
    function automatic curve_pair_t predict_curves(input tsp_pkg::x_t x);
        curve_pair_t pair;
        longint      xl;
        longint      line;
        int          seg;
        xl  = x;
        seg = 0;
        while (seg < tsp_pkg::TANH_SEGS - 1 && xl >= tanh_knee[seg])
            seg++;
        line = (tanh_gain[seg] * xl * 2 + tanh_offset[seg]) >>> tsp_pkg::TANH_SHIFT;
        pair.tanh_q = line[tsp_pkg::TANH_W-1:0];
        seg = 0;
        while (seg < tsp_pkg::SECH_SEGS - 1 && xl >= sech_knee[seg])
            seg++;
        line = (sech_gain[seg] * xl * 2 + sech_offset[seg]) >>> tsp_pkg::SECH_SHIFT;
        pair.sech2_q = line[tsp_pkg::SECH_W-1:0];
        return pair;
    endfunction

    // random argument: full range, the busy +-8.0 band, or close to a boundary
    function automatic tsp_pkg::x_t draw_x();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return tsp_pkg::x_t'($urandom);
        if (pick == 3)
            return tsp_pkg::x_t'(sech_knee[$urandom_range(0, tsp_pkg::SECH_SEGS - 2)]
                                 + longint'($urandom_range(0, 16)) - 8);
        return tsp_pkg::x_t'(int'($urandom_range(0, 33554431)) - 16777216);
    endfunction

    function automatic int draw_idle(input bit enabled);
        if (!enabled)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // drive one argument and hold it until the transaction is taken
    task automatic send_x(input tsp_pkg::x_t x);
        int gap;
        gap = draw_idle(source_gaps);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        x_value  <= x;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_x(draw_x());
    endtask

    task automatic test_segment_boundaries();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        foreach (boundary_args[i])
            send_x(boundary_args[i]);
    endtask

    task automatic test_full_rate(input int count);
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        send_random(count);
    endtask

    task automatic test_sender_gaps(input int count);
        source_gaps = 1'b1;
        sink_stalls = 1'b0;
        send_random(count);
    endtask

    task automatic test_receiver_stalls(input int count);
        source_gaps = 1'b0;
        sink_stalls = 1'b1;
        send_random(count);
    endtask

    task automatic test_random_handshake(input int count);
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_random(count);
    endtask

    task automatic test_drain_pause();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        send_random(50);
        wait_for_drain();
        send_random(50);
    endtask

    // receiver side: random stall before each result
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_idle(sink_stalls);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // record the expected result of each input transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_pairs.push_back(predict_curves(x_value));
    end

    // compare each output transaction with the oldest expectation
    always @(posedge clk)
    begin
        curve_pair_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tanh %0d sech2 %0d",
                         $time, tanh_value, sech2_value);
                mismatch_count++;
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (tanh_value !== want.tanh_q)
                begin
                    $display("%0t: tanh_value expected %0d actual %0d",
                             $time, want.tanh_q, tanh_value);
                    mismatch_count++;
                end
                if (sech2_value !== want.sech2_q)
                begin
                    $display("%0t: sech2_value expected %0d actual %0d",
                             $time, want.sech2_q, sech2_value);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tanh_sech2_piecewise_linear_unit_tb failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_segment_boundaries();
        test_full_rate(200);
        test_sender_gaps(150);
        test_receiver_stalls(150);
        test_drain_pause();
        test_random_handshake(550);

        wait_for_drain();
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatch_count == 0)
            $display("tanh_sech2_piecewise_linear_unit_tb passed");
        else
            $display("tanh_sech2_piecewise_linear_unit_tb failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_coef_lut.sv
hw/rtl/tsp_line_eval.sv
hw/rtl/tanh_sech2_piecewise_linear_unit.sv
tb/tanh_sech2_piecewise_linear_unit_tb.sv
